// ===== sv/rfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Request FIFO with client purge: shared package
// Widths, operation and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfcp_pkg;

   // Queue geometry.
   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int HANDLE_W = 32;
   localparam int CLIENT_W = 8;
   localparam int TIME_W   = 32;
   localparam int LIM_W    = 5;
   localparam int LEN_W    = 5;
   localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

   // Entry layout, lowest bits first: handle, client id, arrival time.
   localparam int CLIENT_LO   = HANDLE_W;
   localparam int ENTRY_W     = HANDLE_W + CLIENT_W + TIME_W;
   localparam int REQ_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
   localparam int RSP_USED_W  = ENTRY_W + LEN_W + LEN_W + 1;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_PURGE = 2'd2,
      FUNC_PEEK  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;          // capture the accepted transaction, clear scan counters
      logic rd_head;        // read the head slot
      logic rd_scan;        // read the slot under the scan index
      logic scan_step;      // compare the scanned entry, compact, advance
      logic finish_simple;  // commit push, pop or peek and load the result
      logic finish_purge;   // commit the purge and load the result
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic req_is_purge;   // the offered transaction is a purge
      logic scan_done;      // every queued entry has been scanned
      logic out_free;       // the result register can take a new result
   } dp_stat_type;

endpackage

// ===== sv/rfcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Request FIFO with client purge: controller
// Sequences one transaction at a time: a single execute step for push, pop
// and peek, or a read-and-compact walk over the queue for a purge.
// ----------------------------------------------------------------------------
module rfcp_ctrl
   import rfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch   = 1'b1;
               cmd.rd_head = 1'b1;
               state_in    = stat.req_is_purge ? S_SCAN_RD : S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.finish_simple = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cmd.scan_step = 1'b1;
            state_in      = S_SCAN_RD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish_purge = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/rfcp_datapath.sv =====
// ----------------------------------------------------------------------------
// Request FIFO with client purge: datapath
// Circular entry memory with head pointer and occupancy, the limit register,
// the purge scan counters and the result register.
// ----------------------------------------------------------------------------
module rfcp_datapath
   import rfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_wr_en,
   input  logic [LIM_W-1:0]      csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   // Slot address of base + off, wrapped around the depth. off <= DEPTH.
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   // Occupancy at or above min(limit, DEPTH).
   function automatic logic at_limit(input logic [CNT_W-1:0] cnt,
                                     input logic [LIM_W-1:0] lim);
      logic [CMP_W-1:0] eff;
      eff = (CMP_W'(lim) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(lim);
      return CMP_W'(cnt) >= eff;
   endfunction

   logic [ENTRY_W-1:0]    entry_ff [DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;

   func_type              func_ff, func_in;
   logic [ENTRY_W-1:0]    op_ff, op_in;
   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [ENTRY_W-1:0]    mem_wr_data;

   logic                  load;
   status_type            res_status;
   logic [ENTRY_W-1:0]    res_entry;
   logic [LEN_W-1:0]      res_removed;
   logic [CNT_W-1:0]      new_count;

   assign stat.req_is_purge = (func_type'(req_tuser) == FUNC_PURGE);
   assign stat.scan_done    = (idx_ff == count_ff);
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

   assign mem_rd_en   = cmd.rd_head || cmd.rd_scan;
   assign mem_rd_addr = cmd.rd_scan ? wrap_add(head_ff, idx_ff) : head_ff;

   always_comb begin
      func_in       = func_ff;
      op_in         = op_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wrap_add(head_ff, count_ff);
      mem_wr_data   = op_ff;
      load          = 1'b0;
      res_status    = STAT_OK;
      res_entry     = '0;
      res_removed   = '0;
      new_count     = count_ff;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.latch) begin
         func_in = func_type'(req_tuser);
         op_in   = req_tdata[ENTRY_W-1:0];
         idx_in  = '0;
         kept_in = '0;
      end

      // Purge walk: entries that survive move down to the kept position.
      if (cmd.scan_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (rd_data_ff[CLIENT_LO +: CLIENT_W] != op_ff[CLIENT_LO +: CLIENT_W]) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wrap_add(head_ff, kept_ff);
            mem_wr_data = rd_data_ff;
            kept_in     = kept_ff + CNT_W'(1);
         end
      end

      if (cmd.finish_simple) begin
         load = 1'b1;
         case (func_ff)
            FUNC_PUSH: begin
               if (at_limit(count_ff, limit_ff)) begin
                  res_status = STAT_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  new_count = count_ff + CNT_W'(1);
               end
            end
            FUNC_POP, FUNC_PEEK: begin
               if (count_ff == '0) begin
                  res_status = STAT_EMPTY;
               end else begin
                  res_entry = rd_data_ff;
                  if (func_ff == FUNC_POP) begin
                     head_in   = wrap_add(head_ff, CNT_W'(1));
                     new_count = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               res_status = STAT_OK;
            end
         endcase
      end

      if (cmd.finish_purge) begin
         load        = 1'b1;
         new_count   = kept_ff;
         res_removed = LEN_W'(count_ff - kept_ff);
      end

      if (load) begin
         count_in      = new_count;
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_data_in   = {{RSP_PAD_W{1'b0}}, at_limit(new_count, limit_ff),
                          LEN_W'(new_count), res_removed, res_entry};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         entry_ff[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= entry_ff[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         idx_ff       <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         idx_ff       <= idx_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      op_ff         <= op_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== sv/request_fifo_with_client_purge.sv =====
// ----------------------------------------------------------------------------
// Request FIFO with client purge
// Bounded first-in first-out request queue with push, pop, peek and a purge
// that removes every entry of one client id while keeping the order of the
// rest. Every transaction produces exactly one result.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                    | Contents
//   --------+-----------+------------------------------+---------------------------------
//   req     | in        | req_tvalid / req_tready      | tuser: func; tdata: entry fields
//   rsp     | out       | rsp_tvalid / rsp_tready      | tuser: status; tdata: result
//   csr     | in        | csr_wr_en (no back-pressure) | queue_limit
//
// Push, pop and peek pass through an accept step that reads the head slot of
// the entry memory and an execute step that commits and loads the result
// register once it is free. A purge walks the queue through the single read
// port of the entry memory: each entry is read, then compared and moved.
// Reset clears occupancy, the head pointer and the result register, and loads
// the limit with 16. The entry memory needs no clearing, since no unoccupied
// slot reaches a result. A stalled result register holds the next result back,
// and a new transaction is accepted while a finished result still waits to be taken.
//
module request_fifo_with_client_purge
   import rfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata, lowest bit up: request_handle[31:0], client_id[39:32],
   // arrival_time[71:40].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: func (0 push, 1 pop, 2 purge, 3 peek).
   input  logic [FUNC_W-1:0]     req_tuser,

   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata, lowest bit up: out_handle[31:0], out_client[39:32],
   // out_arrival[71:40], removed_count[76:72], queue_length[81:77],
   // is_full[82], zero fill[87:83].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status (0 ok, 1 full, 2 empty).
   output logic [STATUS_W-1:0]   rsp_tuser,

   // Configuration: queue_limit.
   input  logic                  csr_wr_en,
   input  logic [LIM_W-1:0]      csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The controller steps through each transaction and issues commands.
   rfcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds the queue, the limit and the result register.
   rfcp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
